// ===== design/crrm_pkg.sv =====
// Package for the contiguous ring region manager.
// Holds the sizes, operation and register codes, and the structs shared by the
// top level and the operation engine. Depends on nothing.
package crrm_pkg;

	localparam int MAX_DEPTH = 1024;
	localparam int MIN_DEPTH = 2;
	localparam int PTR_W     = $clog2(MAX_DEPTH + 1);
	localparam int OFS_W     = 10;
	localparam int EB_W      = 9;
	localparam int BOFS_W    = 18;
	localparam int OP_W      = 3;
	localparam int CFG_W     = 11;
	localparam int IDX_W     = 1;

	typedef enum logic [OP_W-1:0] {
		OP_RESERVE_WRITE = 3'd0,
		OP_COMMIT_WRITE  = 3'd1,
		OP_RESERVE_READ  = 3'd2,
		OP_COMMIT_READ   = 3'd3,
		OP_CLOSE         = 3'd4,
		OP_STATUS        = 3'd5
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_DEPTH      = 1'b0,
		REG_ELEM_BYTES = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PTR_W-1:0] rd;
		logic [PTR_W-1:0] wr;
		logic [PTR_W-1:0] wrap;
		logic             closed;
	} ring_state_t;

	typedef struct packed {
		logic             granted;
		logic [PTR_W-1:0] start;
		logic [PTR_W-1:0] avail;
	} region_t;

endpackage

// ===== design/crrm_engine.sv =====
// Operation engine of the contiguous ring region manager.
// Holds the ring pointers and decides one operation per cycle.
// Depends on crrm_pkg.
module crrm_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid,
	input  logic [crrm_pkg::OP_W-1:0] op,
	input  logic [crrm_pkg::PTR_W-1:0] count,
	input  logic [crrm_pkg::PTR_W-1:0] depth,
	output crrm_pkg::ring_state_t     state,
	output crrm_pkg::region_t         region
);
	import crrm_pkg::*;

	ring_state_t      state_q;
	ring_state_t      nxt;
	logic [PTR_W:0]   end_w;
	logic [PTR_W:0]   rd_sum;
	logic [PTR_W:0]   depth_x;
	logic [PTR_W-1:0] wrap_new;
	logic [PTR_W-1:0] rd_new;
	logic             fit_fail;

	assign depth_x = {1'b0, depth};
	assign end_w   = {1'b0, state_q.wr} + {1'b0, count};
	assign rd_sum  = {1'b0, state_q.rd} + {1'b0, count};

	always_comb begin
		nxt      = state_q;
		region   = '0;
		wrap_new = state_q.wrap;
		rd_new   = state_q.rd;
		fit_fail = 1'b0;
		unique case (op_t'(op))
			OP_RESERVE_WRITE: begin
				if (end_w > depth_x) begin
					// Region does not fit before the end: if the reader leaves room, it goes to slot 0 and the
					// old write position becomes the wrap mark.
					if (state_q.rd > count && state_q.rd <= state_q.wr) begin
						region.granted = 1'b1;
						nxt.wrap       = state_q.wr;
						nxt.wr         = '0;
					end
				end else begin
					if (end_w > {1'b0, state_q.wrap}) begin
						wrap_new = end_w[PTR_W-1:0];
					end
					fit_fail = (state_q.wr < state_q.rd && {1'b0, state_q.rd} <= end_w) ||
						(state_q.rd > wrap_new);
					if (!fit_fail) begin
						region.granted = 1'b1;
						region.start   = state_q.wr;
						nxt.wrap       = wrap_new;
					end
				end
			end
			OP_COMMIT_WRITE: begin
				nxt.wr = (end_w > depth_x) ? depth : end_w[PTR_W-1:0];
			end
			OP_RESERVE_READ: begin
				// A reader sitting on the wrap mark jumps back to slot 0 first.
				if (state_q.rd > state_q.wr && state_q.rd == state_q.wrap) begin
					rd_new = '0;
				end
				nxt.rd = rd_new;
				if (rd_new != state_q.wr) begin
					region.granted = 1'b1;
					region.start   = rd_new;
					region.avail   = (rd_new < state_q.wr) ? (state_q.wr - rd_new) :
						(state_q.wrap - rd_new);
				end
			end
			OP_COMMIT_READ: begin
				nxt.rd = (rd_sum > depth_x) ? depth : rd_sum[PTR_W-1:0];
			end
			OP_CLOSE: begin
				nxt.closed = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid) begin
			state_q <= nxt;
		end
	end

	assign state = state_q;

`ifndef SYNTHESIS
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.closed |=> state_q.closed)
		else $error("closed flag dropped");
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!valid |=> $stable(state_q))
		else $error("ring state changed without an operation");
	a_grant_start: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && op_t'(op) == OP_RESERVE_WRITE && region.granted && end_w > depth_x)
		|-> region.start == '0)
		else $error("wrapped write region does not start at slot zero");
`endif

endmodule

// ===== design/contiguous_ring_region_manager.sv =====
// Top level of the contiguous ring region manager.
// Registers the command and configuration, runs crrm_engine, and forms the
// status and byte offset of each result. Depends on crrm_pkg and crrm_engine.
//
// This block keeps the read, write and wrap pointers of a ring that hands out
// contiguous regions; the data memory lives elsewhere. A command is accepted
// at every clock edge where start is high and busy is low, and busy is always
// low, so one item can be issued in every cycle. Each item gives exactly one
// result, in issue order. Done goes high once the item has passed through
// the registers valid_s1, valid_s2 and done_q, and stays high for a single
// cycle. The receiver cannot stall, so results must be captured when done is
// high. The figure of one item a cycle is set by the pointer update in
// crrm_engine, which reads and writes the ring state in the same cycle; the
// status fields and the byte offset multiply are computed one stage later
// from the state that the item left behind. Configuration writes
// (depth_in_use, element_bytes) take effect at once and must only be made
// while no item is in flight. Out of range depths are clamped to the
// range two to MAX_DEPTH when written. No clearing pass follows reset.
module contiguous_ring_region_manager (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [crrm_pkg::OP_W-1:0]     operation,
	input  logic [crrm_pkg::PTR_W-1:0]    count,
	input  logic                          wr_en,
	input  logic [crrm_pkg::IDX_W-1:0]    wr_index,
	input  logic [crrm_pkg::CFG_W-1:0]    wr_data,
	output logic                          done,
	output logic                          granted,
	output logic [crrm_pkg::OFS_W-1:0]    offset,
	output logic [crrm_pkg::BOFS_W-1:0]   byte_offset,
	output logic [crrm_pkg::PTR_W-1:0]    available,
	output logic [crrm_pkg::PTR_W-1:0]    used_count,
	output logic [crrm_pkg::PTR_W-1:0]    free_span,
	output logic                          empty_res,
	output logic                          closed
);
	import crrm_pkg::*;

	localparam int PROD_W = PTR_W + EB_W;

	// Configuration registers. The depth is stored already clamped.
	logic [PTR_W-1:0] depth_q;
	logic [EB_W-1:0]  elem_bytes_q;

	// Command stage.
	logic             valid_s1;
	logic [OP_W-1:0]  op_s1;
	logic [PTR_W-1:0] count_s1;

	// Decision stage.
	logic             valid_s2;
	region_t          region_s2;

	ring_state_t      ring;
	region_t          region;

	// Output registers.
	logic              done_q;
	logic              granted_q;
	logic [OFS_W-1:0]  offset_q;
	logic [BOFS_W-1:0] byte_offset_q;
	logic [PTR_W-1:0]  available_q;
	logic [PTR_W-1:0]  used_q;
	logic [PTR_W-1:0]  free_q;
	logic              empty_q;
	logic              closed_q;

	// Status of the state after the item in the decision stage.
	logic [PTR_W:0]    wr_plus_d;
	logic [PTR_W-1:0]  used_c;
	logic [PTR_W-1:0]  tail_c;
	logic [PTR_W-1:0]  head_c;
	logic [PTR_W-1:0]  free_c;
	logic              empty_c;
	logic [PROD_W-1:0] product;
	logic [CFG_W-1:0]  depth_clamped;

	assign busy = 1'b0;

	always_comb begin
		if (wr_data < CFG_W'(MIN_DEPTH)) begin
			depth_clamped = CFG_W'(MIN_DEPTH);
		end else if (wr_data > CFG_W'(MAX_DEPTH)) begin
			depth_clamped = CFG_W'(MAX_DEPTH);
		end else begin
			depth_clamped = wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= PTR_W'(MAX_DEPTH);
			elem_bytes_q <= EB_W'(4);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_DEPTH:      depth_q      <= PTR_W'(depth_clamped);
				REG_ELEM_BYTES: elem_bytes_q <= wr_data[EB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= operation;
		count_s1  <= count;
		region_s2 <= region;
	end

	crrm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.op     (op_s1),
		.count  (count_s1),
		.depth  (depth_q),
		.state  (ring),
		.region (region)
	);

	// While an item sits in the decision stage, the ring registers already hold
	// the state it produced, so the status fields come straight from them.
	assign wr_plus_d = {1'b0, ring.wr} + {1'b0, depth_q};

	always_comb begin
		if (ring.rd <= ring.wr) begin
			used_c = ring.wr - ring.rd;
			tail_c = (depth_q > ring.wr) ? (depth_q - ring.wr) : '0;
			head_c = (ring.rd != '0) ? (ring.rd - PTR_W'(1)) : '0;
			free_c = (tail_c > head_c) ? tail_c : head_c;
		end else begin
			// A pointer beyond a shrunken depth saturates the used count at zero.
			used_c = (wr_plus_d > {1'b0, ring.rd}) ?
				PTR_W'(wr_plus_d - {1'b0, ring.rd}) : '0;
			tail_c = '0;
			head_c = '0;
			free_c = ring.rd - ring.wr - PTR_W'(1);
		end
		empty_c = (ring.rd == ring.wr) || (ring.wr == '0 && ring.rd == ring.wrap);
	end

	assign product = PROD_W'(region_s2.start) * PROD_W'(elem_bytes_q);

	always_ff @(posedge clk) begin
		granted_q     <= region_s2.granted;
		offset_q      <= region_s2.start[OFS_W-1:0];
		byte_offset_q <= product[BOFS_W-1:0];
		available_q   <= region_s2.avail;
		used_q        <= used_c;
		free_q        <= free_c;
		empty_q       <= empty_c;
		closed_q      <= ring.closed;
	end

	assign done        = done_q;
	assign granted     = granted_q;
	assign offset      = offset_q;
	assign byte_offset = byte_offset_q;
	assign available   = available_q;
	assign used_count  = used_q;
	assign free_span   = free_q;
	assign empty_res   = empty_q;
	assign closed      = closed_q;

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> valid_s1)
		else $error("accepted item did not enter the command stage");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |=> done)
		else $error("decided item produced no result");
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1, 2))
		else $error("result without a matching item");
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !granted) |-> (offset == '0 && byte_offset == '0 && available == '0))
		else $error("refused item carries a region");
`endif

endmodule

// ===== tb/contiguous_ring_region_manager_tb.sv =====
// Testbench for the contiguous ring region manager.
// Drives commands and register writes, predicts each result in a behavioral
// ring model and checks every result as it leaves. Depends on crrm_pkg.
module contiguous_ring_region_manager_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crrm_pkg::*;

	// Command codes six and seven have no enum member; the block treats them as
	// a status request.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	// The drain wait covers the pipeline from command to result with margin, and
	// the watchdog trips on a long stretch with no traffic.
	localparam int DRAIN_CYCLES = 6;
	localparam int STALL_LIMIT  = 2000;
	localparam int MAX_REPORTS  = 10;

	// One result item as the block presents it, in port order.
	typedef struct packed {
		logic              granted;
		logic [OFS_W-1:0]  offset;
		logic [BOFS_W-1:0] byte_offset;
		logic [PTR_W-1:0]  available;
		logic [PTR_W-1:0]  used_count;
		logic [PTR_W-1:0]  free_span;
		logic              empty_res;
		logic              closed;
	} ring_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [OP_W-1:0]   operation = OP_STATUS;
	logic [PTR_W-1:0]  count = '0;
	logic              wr_en = 1'b0;
	logic [IDX_W-1:0]  wr_index = REG_DEPTH;
	logic [CFG_W-1:0]  wr_data = '0;
	logic              done;
	logic              granted;
	logic [OFS_W-1:0]  offset;
	logic [BOFS_W-1:0] byte_offset;
	logic [PTR_W-1:0]  available;
	logic [PTR_W-1:0]  used_count;
	logic [PTR_W-1:0]  free_span;
	logic              empty_res;
	logic              closed;

	contiguous_ring_region_manager i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.count       (count),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.done        (done),
		.granted     (granted),
		.offset      (offset),
		.byte_offset (byte_offset),
		.available   (available),
		.used_count  (used_count),
		.free_span   (free_span),
		.empty_res   (empty_res),
		.closed      (closed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Behavioral copy of the ring. Register values are kept as written (masked
	// to their widths); the depth is clamped when it is used.
	int unsigned ring_depth_reg = 1024;
	int unsigned ring_elem_bytes = 4;
	int unsigned ring_rd = 0;
	int unsigned ring_wr = 0;
	int unsigned ring_wrap = 0;
	bit          ring_closed = 1'b0;

	ring_result_t pending_results[$];
	int           fails = 0;
	int           stalled_cycles = 0;
	int           sender_idle_pct = 0;

	function automatic int unsigned depth_now();
		if (ring_depth_reg < MIN_DEPTH)
			return MIN_DEPTH;
		if (ring_depth_reg > MAX_DEPTH)
			return MAX_DEPTH;
		return ring_depth_reg;
	endfunction

	// Tries to place a write region of n slots. The region goes at the write
	// pointer when it fits before the end of the ring, otherwise it wraps to slot
	// zero and the old write pointer becomes the wrap mark. Returns the first
	// slot of the region, or -1 when the reader is in the way.
	function automatic int claim_region(int unsigned n);
		int unsigned first, last, mark;
		bit          wrapped;
		first = ring_wr;
		last = first + n;
		mark = ring_wrap;
		wrapped = 1'b0;
		if (last > depth_now()) begin
			if (ring_rd <= n)
				return -1;
			last = n;
			mark = first;
			first = 0;
			wrapped = 1'b1;
		end else if (last > mark) begin
			mark = last;
		end
		if ((first < ring_rd && ring_rd <= last) || ring_rd > mark ||
			(wrapped && ring_rd <= last))
			return -1;
		ring_wrap = mark;
		if (first == 0)
			ring_wr = 0;
		return first;
	endfunction

	// Applies one command to the ring copy and returns the result it must give.
	// Spans are worked out signed so that pointers left beyond a shrunken depth
	// give zero rather than a wrapped count.
	function automatic ring_result_t advance_ring(logic [OP_W-1:0] op, logic [PTR_W-1:0] n);
		ring_result_t want;
		int unsigned  d, first, run;
		int           slot, r, w, span;
		bit           ok;
		d = depth_now();
		ok = 1'b0;
		first = 0;
		run = 0;
		case (op)
			OP_RESERVE_WRITE: begin
				slot = claim_region(n);
				if (slot >= 0) begin
					ok = 1'b1;
					first = slot;
				end
			end
			OP_COMMIT_WRITE: begin
				ring_wr = (ring_wr + n > d) ? d : ring_wr + n;
			end
			OP_RESERVE_READ: begin
				// A reader parked on the wrap mark jumps back to slot zero first.
				if (ring_rd > ring_wr && ring_rd == ring_wrap)
					ring_rd = 0;
				if (ring_rd < ring_wr) begin
					ok = 1'b1;
					first = ring_rd;
					run = ring_wr - ring_rd;
				end else if (ring_rd > ring_wr) begin
					ok = 1'b1;
					first = ring_rd;
					run = ring_wrap - ring_rd;
				end
			end
			OP_COMMIT_READ: begin
				ring_rd = (ring_rd + n > d) ? d : ring_rd + n;
			end
			OP_CLOSE: begin
				ring_closed = 1'b1;
			end
			default: begin
			end
		endcase
		r = ring_rd;
		w = ring_wr;
		want.granted = ok;
		want.offset = OFS_W'(first);
		want.byte_offset = BOFS_W'(first * ring_elem_bytes);
		want.available = PTR_W'(run);
		span = (r <= w) ? w - r : w + int'(d) - r;
		want.used_count = (span < 0) ? '0 : PTR_W'(span);
		if (r <= w)
			span = (int'(d) - w > r - 1) ? int'(d) - w : r - 1;
		else
			span = r - w - 1;
		want.free_span = (span < 0) ? '0 : PTR_W'(span);
		want.empty_res = (ring_rd == ring_wr) || (ring_wr == 0 && ring_rd == ring_wrap);
		want.closed = ring_closed;
		return want;
	endfunction

	// Issues one command after a random gap, waits for the edge that takes it,
	// and queues the result it must produce. Start is left high so that the
	// next command can follow in the very next cycle.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [PTR_W-1:0] n,
		output ring_result_t want);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		count <= n;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		want = advance_ring(op, n);
		pending_results.push_back(want);
	endtask

	// Stops issuing and waits for every queued result, then lets the pipeline
	// settle. Registers may only change after this.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both registers on back to back edges; wr_en stays high between.
	task automatic write_config(input logic [CFG_W-1:0] depth, input logic [CFG_W-1:0] eb);
		wr_en <= 1'b1;
		wr_index <= REG_DEPTH;
		wr_data <= depth;
		@(posedge clk);
		ring_depth_reg = depth;
		wr_index <= REG_ELEM_BYTES;
		wr_data <= eb;
		@(posedge clk);
		ring_elem_bytes = eb & 11'h1FF;
		wr_en <= 1'b0;
	endtask

	// Status from the reset state, including the two unused command codes.
	task automatic test_spare_codes();
		ring_result_t want;
		send_item(OP_STATUS, '0, want);
		send_item(OP_SPARE_LO, 11'h7FF, want);
		send_item(OP_SPARE_HI, 11'h2AA, want);
	endtask

	// Fills the whole ring, overshoots both commits, reads it back out and then
	// forces a wrap, so the reader has to jump from the wrap mark to slot zero.
	// The widest element size makes the byte offset overflow its field.
	task automatic test_full_ring();
		ring_result_t want;
		drain_results();
		write_config(11'd1024, 11'd511);
		send_item(OP_RESERVE_WRITE, 11'd0, want);
		send_item(OP_RESERVE_WRITE, 11'd1024, want);
		send_item(OP_COMMIT_WRITE, 11'h7FF, want);
		// Write pointer sits on the end of the ring: an empty region there
		// starts at slot 1024, which is wider than the offset field.
		send_item(OP_RESERVE_WRITE, 11'd0, want);
		send_item(OP_RESERVE_WRITE, 11'h7FF, want);
		send_item(OP_RESERVE_READ, '0, want);
		send_item(OP_COMMIT_READ, 11'h7FF, want);
		send_item(OP_RESERVE_READ, '0, want);
		send_item(OP_RESERVE_WRITE, 11'd5, want);
		send_item(OP_COMMIT_WRITE, 11'd5, want);
		send_item(OP_RESERVE_READ, '0, want);
		send_item(OP_COMMIT_READ, 11'd5, want);
	endtask

	// Shrinks the ring below the pointers, with out of range register values,
	// so that the used count and the room past the write pointer must saturate at zero.
	task automatic test_shrunken_depth();
		ring_result_t want;
		drain_results();
		write_config(11'd0, 11'd0);
		send_item(OP_STATUS, '0, want);
		send_item(OP_COMMIT_WRITE, 11'd3, want);
		send_item(OP_RESERVE_WRITE, 11'd1, want);
		send_item(OP_RESERVE_READ, '0, want);
		send_item(OP_COMMIT_READ, 11'h7FF, want);
		send_item(OP_STATUS, '0, want);
		drain_results();
		write_config(11'h7FF, 11'd256);
		send_item(OP_STATUS, '0, want);
	endtask

	function automatic logic [PTR_W-1:0] region_size();
		int unsigned d;
		d = depth_now();
		if ($urandom_range(0, 3) == 0)
			return PTR_W'($urandom_range(0, d));
		return PTR_W'($urandom_range(1, d / 4 + 1));
	endfunction

	// Random traffic. Most of it is the normal producer and consumer pattern:
	// reserve then commit what was granted, read the run then release it, with
	// the odd short commit. The rest is any command with any count.
	task automatic run_traffic(input int n_items, input int idle_pct, input bit with_close);
		ring_result_t     want;
		int               sent, kind;
		logic [PTR_W-1:0] n;
		logic [OP_W-1:0]  op;
		sender_idle_pct = idle_pct;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				n = region_size();
				send_item(OP_RESERVE_WRITE, n, want);
				sent++;
				if (want.granted) begin
					if ($urandom_range(0, 7) == 0)
						n = PTR_W'($urandom_range(0, n));
					send_item(OP_COMMIT_WRITE, n, want);
					sent++;
				end
			end else if (kind < 70) begin
				send_item(OP_RESERVE_READ, PTR_W'($urandom_range(0, 2047)), want);
				sent++;
				if (want.granted) begin
					n = want.available;
					if ($urandom_range(0, 3) == 0)
						n = PTR_W'($urandom_range(0, n));
					send_item(OP_COMMIT_READ, n, want);
					sent++;
				end
			end else if (kind < 76) begin
				send_item(OP_STATUS, PTR_W'($urandom_range(0, 2047)), want);
				sent++;
			end else begin
				op = OP_W'($urandom_range(0, 7));
				if (op == OP_CLOSE && !with_close)
					op = OP_STATUS;
				if (kind < 88)
					n = PTR_W'($urandom_range(0, 2047));
				else
					n = PTR_W'($urandom_range(0, depth_now() + 2));
				send_item(op, n, want);
				sent++;
			end
		end
	endtask

	// Several register settings, the extremes and out of range values among
	// them, each with its own sender gap rate. The ring is drained before each
	// write, which is also where the sender waits for every result to arrive.
	task automatic test_random_phases();
		logic [CFG_W-1:0] depth_set[9] = '{11'd1024, 11'd2, 11'd16, 11'd1, 11'd100,
			11'd1025, 11'd37, 11'd2047, 11'd5};
		logic [CFG_W-1:0] eb_set[9]    = '{11'd4, 11'd1, 11'd256, 11'd3, 11'd0,
			11'd511, 11'd7, 11'd256, 11'd2};
		int idle_set[9]  = '{0, 49, 0, 16, 49, 16, 0, 49, 16};
		for (int p = 0; p < 9; p++) begin
			drain_results();
			write_config(depth_set[p], eb_set[p]);
			run_traffic(150, idle_set[p], 1'b0);
		end
	endtask

	// Close is sticky and there is no second reset, so it comes last; traffic
	// after it must behave exactly as before apart from the closed bit.
	task automatic test_close();
		ring_result_t want;
		drain_results();
		write_config(11'd64, 11'd8);
		sender_idle_pct = 0;
		send_item(OP_CLOSE, 11'h7FF, want);
		send_item(OP_STATUS, '0, want);
		send_item(OP_CLOSE, '0, want);
		send_item(OP_RESERVE_READ, '0, want);
		run_traffic(60, 16, 1'b1);
	endtask

	// Every result is checked against the oldest outstanding expectation.
	always @(posedge clk) begin
		ring_result_t seen, want;
		if (arst_n && done === 1'b1) begin
			seen = {granted, offset, byte_offset, available, used_count, free_span,
				empty_res, closed};
			if (pending_results.size() == 0) begin
				if (fails < MAX_REPORTS)
					$display("%0t: result with nothing outstanding", $realtime);
				fails++;
			end else begin
				want = pending_results.pop_front();
				if (seen !== want) begin
					if (fails < MAX_REPORTS) begin
						$display("%0t: result mismatch (expected / actual)", $realtime);
						$display("  granted %0d/%0d offset %0d/%0d byte_offset %0d/%0d",
							want.granted, seen.granted, want.offset, seen.offset,
							want.byte_offset, seen.byte_offset);
						$display("  available %0d/%0d used %0d/%0d free %0d/%0d",
							want.available, seen.available, want.used_count,
							seen.used_count, want.free_span, seen.free_span);
						$display("  empty %0d/%0d closed %0d/%0d",
							want.empty_res, seen.empty_res, want.closed, seen.closed);
					end
					fails++;
				end
			end
		end
	end

	// Watchdog: any accepted command or delivered result counts as progress.
	always @(posedge clk) begin
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else if (!arst_n || (start && !busy) || done) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_spare_codes();
		test_full_ring();
		test_shrunken_depth();
		test_random_phases();
		test_close();
		drain_results();
		if (fails == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
